FILE: rtl/core/three_axis_moving_average_macros.svh
// Assertion macros used by the filter's top-level RTL file.
`ifndef THREE_AXIS_MOVING_AVERAGE_MACROS_SVH
`define THREE_AXIS_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TAM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TAM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/tam_pkg.sv
package tam_pkg;

    localparam int WINDOW_DEF      = 32;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int AXES            = 3;

    typedef struct packed {
        logic            vld;
        logic            full;
        logic [AXES-1:0] neg;
    } t_side;

endpackage

FILE: rtl/core/tam_ifs.sv
interface tam_in_if
    import tam_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                    output ready);
endinterface

interface tam_out_if
    import tam_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mean_x;
    logic signed [SAMPLE_BITS-1:0] mean_y;
    logic signed [SAMPLE_BITS-1:0] mean_z;
    logic                          mean_valid;

    modport source (output valid, output mean_x, output mean_y, output mean_z,
                    output mean_valid, input ready);
    modport sink   (input valid, input mean_x, input mean_y, input mean_z,
                    input mean_valid, output ready);
endinterface

FILE: rtl/core/three_axis_moving_average.sv
// Channel   | Dir | Port      | Word
// ----------+-----+-----------+------------------------------------------
// samples   | in  | i_sample  | sample_x, sample_y, sample_z
// means     | out | o_mean    | mean_x, mean_y, mean_z, mean_valid
//
// One word is taken every cycle while the output side is not stalled.
// A result reaches o_mean through the sum, magnitude, division and output
// registers, in that order.
// Reset clears the sample taps, the running sums and the fill count.
// When o_mean.ready is low with a result waiting, the whole pipeline holds and
// i_sample.ready drops in the same cycle.
`include "three_axis_moving_average_macros.svh"

module three_axis_moving_average
    import tam_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tam_in_if.sink       i_sample,
    tam_out_if.source    o_mean
);

    localparam int LW   = $clog2(WINDOW);
    localparam int SUMW = SAMPLE_BITS + LW;
    localparam int FW   = $clog2(WINDOW + 1);
    localparam int S    = SAMPLE_BITS;

    localparam logic [SUMW-1:0] MAG_MAX = SUMW'(WINDOW) << (S - 1);

    logic                         w_en;
    logic                         w_acc;

    logic [AXES-1:0][S-1:0]       w_tap [WINDOW+1];

    logic [FW-1:0]                r_fill;
    logic [FW-1:0]                n_fill;
    logic [AXES-1:0][SUMW-1:0]    r_sum;
    logic [AXES-1:0][SUMW-1:0]    n_sum;

    t_side                        r_a_side;
    t_side                        n_a_side;
    t_side                        r_b_side;
    t_side                        n_b_side;
    logic [AXES-1:0][SUMW-1:0]    r_b_mag;
    logic [AXES-1:0][SUMW-1:0]    n_b_mag;

    t_side                        w_c_side;
    logic [AXES-1:0][S-1:0]       w_quo;
    logic                         w_mag_ok;

    logic                         r_out_vld;
    logic [AXES-1:0][S-1:0]       r_mean;
    logic [AXES-1:0][S-1:0]       n_mean;
    logic                         r_mean_valid;

    assign w_en           = !r_out_vld || o_mean.ready;
    assign i_sample.ready = w_en;
    assign w_acc          = i_sample.valid && w_en;

    assign w_tap[0][0] = i_sample.sample_x;
    assign w_tap[0][1] = i_sample.sample_y;
    assign w_tap[0][2] = i_sample.sample_z;

    for (genvar g = 0; g < WINDOW; g++) begin : g_tap
        tam_tap_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_tap (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_acc),
            .i_d     (w_tap[g]),
            .o_q     (w_tap[g+1])
        );
    end

    always_comb begin
        n_fill = (r_fill == FW'(WINDOW)) ? r_fill : FW'(r_fill + 1'b1);
        for (int a = 0; a < AXES; a++) begin
            n_sum[a] = r_sum[a]
                     + {{LW{w_tap[0][a][S-1]}}, w_tap[0][a]}
                     - {{LW{w_tap[WINDOW][a][S-1]}}, w_tap[WINDOW][a]};
        end
        n_a_side      = '0;
        n_a_side.vld  = w_acc;
        n_a_side.full = (n_fill == FW'(WINDOW));
    end

    always_comb begin
        n_b_side = r_a_side;
        for (int a = 0; a < AXES; a++) begin
            n_b_side.neg[a] = r_sum[a][SUMW-1];
            n_b_mag[a]      = r_sum[a][SUMW-1] ? SUMW'(~r_sum[a] + 1'b1) : r_sum[a];
        end
    end

    tam_div_cell #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (r_b_side),
        .i_mag   (r_b_mag),
        .o_side  (w_c_side),
        .o_quo   (w_quo)
    );

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            if (!w_c_side.full) begin
                n_mean[a] = '0;
            end else if (w_c_side.neg[a]) begin
                n_mean[a] = S'(~w_quo[a] + 1'b1);
            end else begin
                n_mean[a] = w_quo[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_sum     <= '0;
            r_a_side  <= '0;
            r_b_side  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_acc) begin
                r_fill <= n_fill;
                r_sum  <= n_sum;
            end
            if (w_en) begin
                r_a_side     <= n_a_side;
                r_b_side     <= n_b_side;
                r_b_mag      <= n_b_mag;
                r_out_vld    <= w_c_side.vld;
                r_mean       <= n_mean;
                r_mean_valid <= w_c_side.full;
            end
        end
    end

    assign o_mean.valid      = r_out_vld;
    assign o_mean.mean_x     = $signed(r_mean[0]);
    assign o_mean.mean_y     = $signed(r_mean[1]);
    assign o_mean.mean_z     = $signed(r_mean[2]);
    assign o_mean.mean_valid = r_mean_valid;

    assign w_mag_ok = (r_b_mag[0] <= MAG_MAX) && (r_b_mag[1] <= MAG_MAX)
                   && (r_b_mag[2] <= MAG_MAX);

    `TAM_ASSERT_IMP(a_valid_needs_full, i_clk, i_rst_n, r_out_vld && r_mean_valid, r_fill == FW'(WINDOW))
    `TAM_ASSERT_IMP(a_zero_until_full, i_clk, i_rst_n, r_out_vld && !r_mean_valid, r_mean == '0)
    `TAM_ASSERT_NXT(a_fill_counts, i_clk, i_rst_n, w_acc, r_fill != '0)
    `TAM_ASSERT_IMP(a_mag_in_range, i_clk, i_rst_n, r_b_side.vld, w_mag_ok)

endmodule

FILE: rtl/core/tam_tap_cell.sv
module tam_tap_cell
    import tam_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic [AXES-1:0][SAMPLE_BITS-1:0]    i_d,
    output logic [AXES-1:0][SAMPLE_BITS-1:0]    o_q
);

    logic [AXES-1:0][SAMPLE_BITS-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

FILE: rtl/core/tam_div_cell.sv
module tam_div_cell
    import tam_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_en,
    input  t_side                                                i_side,
    input  logic [AXES-1:0][SAMPLE_BITS+$clog2(WINDOW)-1:0]      i_mag,
    output t_side                                                o_side,
    output logic [AXES-1:0][SAMPLE_BITS-1:0]                     o_quo
);

    localparam int LW   = $clog2(WINDOW);
    localparam int SUMW = SAMPLE_BITS + LW;
    localparam int SH   = SUMW + LW;
    localparam int PW   = 2 * SUMW + 1;

    localparam longint unsigned RECIP_WIDE =
        ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [SUMW:0] RECIP = (SUMW+1)'(RECIP_WIDE);

    logic [AXES-1:0][PW-1:0]           w_prod;
    logic [AXES-1:0][SAMPLE_BITS-1:0]  n_quo;

    t_side                             r_side;
    logic [AXES-1:0][SAMPLE_BITS-1:0]  r_quo;

    // The magnitude is divided by the window length through a rounded-up
    // reciprocal, which gives the exact floor for every magnitude the sums reach.
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_prod[a] = PW'(i_mag[a]) * PW'(RECIP);
            n_quo[a]  = w_prod[a][SH+SAMPLE_BITS-1:SH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
            r_quo  <= n_quo;
        end
    end

    assign o_side = r_side;
    assign o_quo  = r_quo;

endmodule
